>>> src/burh_pkg.sv
package burh_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int SNAP_WIDTH_DEF    = 64;
    localparam int PORT_SNAP_W       = 64;
    localparam int LEVEL_W           = 7;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_UNDO   = 2'd1;
    localparam logic [1:0] OP_REDO   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_UNDO = 2'd1;
    localparam logic [1:0] ST_NO_REDO = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctrl_t;

endpackage

>>> src/burh_cell.sv
module burh_cell #(
    parameter int SNAP_WIDTH = burh_pkg::SNAP_WIDTH_DEF
) (
    input  logic                    clk,
    input  burh_pkg::stack_ctrl_t   ctrl,
    input  logic [SNAP_WIDTH-1:0]   upper,
    input  logic [SNAP_WIDTH-1:0]   lower,
    output logic [SNAP_WIDTH-1:0]   data
);

    logic [SNAP_WIDTH-1:0] data_reg;
    logic [SNAP_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = upper;
        end
        else if (ctrl.pop)
        begin
            data_next = lower;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> src/burh_stack.sv
module burh_stack #(
    parameter int HISTORY_DEPTH = burh_pkg::HISTORY_DEPTH_DEF,
    parameter int SNAP_WIDTH    = burh_pkg::SNAP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  burh_pkg::stack_ctrl_t         ctrl,
    input  logic [SNAP_WIDTH-1:0]         push_data,
    output logic [SNAP_WIDTH-1:0]         top,
    output logic                          empty,
    output logic [burh_pkg::LEVEL_W-1:0]  level
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [SNAP_WIDTH-1:0] cell_data [HISTORY_DEPTH];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW+burh_pkg::LEVEL_W-1:0] level_wide;

    genvar i;
    generate
        for (i = 0; i < HISTORY_DEPTH; i++)
        begin : g_cell
            logic [SNAP_WIDTH-1:0] up_d;
            logic [SNAP_WIDTH-1:0] lo_d;
            if (i == 0)
            begin : g_first
                assign up_d = push_data;
            end
            else
            begin : g_mid
                assign up_d = cell_data[i-1];
            end
            if (i == HISTORY_DEPTH - 1)
            begin : g_last
                assign lo_d = cell_data[i];
            end
            else
            begin : g_inner
                assign lo_d = cell_data[i+1];
            end
            burh_cell #(
                .SNAP_WIDTH(SNAP_WIDTH)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .upper (up_d),
                .lower (lo_d),
                .data  (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push && !ctrl.pop)
        begin
            if (count_reg != CW'(HISTORY_DEPTH))
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign level_wide = (CW + burh_pkg::LEVEL_W)'(count_reg);
    assign level      = level_wide[burh_pkg::LEVEL_W-1:0];
    assign empty      = (count_reg == '0);
    assign top        = cell_data[0];

endmodule

>>> src/bounded_undo_redo_history.sv
// Latency: the result strobe done is high in the cycle after start is taken.
// busy is high while the result register shows its beat, so no new operation
// is taken before the last result is shown; the stacks shift in the accept cycle.
// Reset: rst_n clears both history levels to empty and drops done; the
// history entries hold no reset value. The receiver cannot stall results.
module bounded_undo_redo_history #(
    parameter int HISTORY_DEPTH = burh_pkg::HISTORY_DEPTH_DEF,
    parameter int SNAP_WIDTH    = burh_pkg::SNAP_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [burh_pkg::PORT_SNAP_W-1:0]   snapshot,
    output logic                               done,
    output logic [burh_pkg::PORT_SNAP_W-1:0]   new_current,
    output logic [1:0]                         status,
    output logic [burh_pkg::LEVEL_W-1:0]       undo_level,
    output logic [burh_pkg::LEVEL_W-1:0]       redo_level
);

    logic                  accept;
    logic [SNAP_WIDTH-1:0] snap;
    logic [SNAP_WIDTH-1:0] undo_top;
    logic [SNAP_WIDTH-1:0] redo_top;
    logic                  undo_empty;
    logic                  redo_empty;

    burh_pkg::stack_ctrl_t undo_ctrl;
    burh_pkg::stack_ctrl_t redo_ctrl;

    logic                  done_reg;
    logic                  done_next;
    logic [SNAP_WIDTH-1:0] cur_reg;
    logic [SNAP_WIDTH-1:0] cur_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;

    assign accept = start && !busy;
    assign snap   = snapshot[SNAP_WIDTH-1:0];

    always_comb
    begin
        undo_ctrl   = '0;
        redo_ctrl   = '0;
        cur_next    = snap;
        status_next = burh_pkg::ST_DONE;
        case (opcode)
            burh_pkg::OP_RECORD:
            begin
                undo_ctrl.push  = accept;
                redo_ctrl.clear = accept;
            end
            burh_pkg::OP_UNDO:
            begin
                if (undo_empty)
                begin
                    status_next = burh_pkg::ST_NO_UNDO;
                end
                else
                begin
                    cur_next       = undo_top;
                    undo_ctrl.pop  = accept;
                    redo_ctrl.push = accept;
                end
            end
            burh_pkg::OP_REDO:
            begin
                if (redo_empty)
                begin
                    status_next = burh_pkg::ST_NO_REDO;
                end
                else
                begin
                    cur_next       = redo_top;
                    redo_ctrl.pop  = accept;
                    undo_ctrl.push = accept;
                end
            end
            default:
            begin
                status_next = burh_pkg::ST_DONE;
            end
        endcase
    end

    assign done_next = accept;

    burh_stack #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SNAP_WIDTH   (SNAP_WIDTH)
    ) u_undo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (undo_ctrl),
        .push_data (snap),
        .top       (undo_top),
        .empty     (undo_empty),
        .level     (undo_level)
    );

    burh_stack #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SNAP_WIDTH   (SNAP_WIDTH)
    ) u_redo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (redo_ctrl),
        .push_data (snap),
        .top       (redo_top),
        .empty     (redo_empty),
        .level     (redo_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= cur_next;
            status_reg <= status_next;
        end
    end

    assign busy        = done_reg;
    assign done        = done_reg;
    assign new_current = burh_pkg::PORT_SNAP_W'(cur_reg);
    assign status      = status_reg;

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted beat gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without an accepted beat");

    a_empty_undo_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == burh_pkg::ST_NO_UNDO) |->
            ($stable(undo_level) && $stable(redo_level)))
        else $error("empty undo changed a level");

    a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == burh_pkg::OP_RECORD) |=> (redo_level == '0))
        else $error("record left redo history");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import burh_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam logic [63:0] SNAP_MASK = {64{1'b1}} >> (64 - SNAP_WIDTH_DEF);
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int UNDO_SIDE = 0;
    localparam int REDO_SIDE = 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        logic [63:0]        cur;
        logic [1:0]         st;
        logic [LEVEL_W-1:0] undo_lvl;
        logic [LEVEL_W-1:0] redo_lvl;
    } outcome_t;

    typedef struct {
        bit       typed;
        outcome_t want;
    } beat_tag_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] snap;
        bit          typed;
        outcome_t    want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [1:0]             opcode = OP_RECORD;
    logic [PORT_SNAP_W-1:0] snapshot = '0;
    logic                   busy;
    logic                   done;
    logic [PORT_SNAP_W-1:0] new_current;
    logic [1:0]             status;
    logic [LEVEL_W-1:0]     undo_level;
    logic [LEVEL_W-1:0]     redo_level;

    bounded_undo_redo_history u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .snapshot    (snapshot),
        .done        (done),
        .new_current (new_current),
        .status      (status),
        .undo_level  (undo_level),
        .redo_level  (redo_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    logic [63:0] hist_word [2][DEPTH];
    int          hist_head [2];
    int          hist_fill [2];

    outcome_t    pending_results [$];
    beat_tag_t   beat_tags [$];
    plan_row_t   plan [$];

    int errors = 0;
    int checked = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int op_count [4];
    int full_pushes = 0;
    int refusals = 0;

    function automatic void hist_push(int side, logic [63:0] w);
        hist_word[side][hist_head[side]] = w;
        hist_head[side] = (hist_head[side] + 1) % DEPTH;
        if (hist_fill[side] < DEPTH)
            hist_fill[side]++;
        else
            full_pushes++;
    endfunction

    function automatic logic [63:0] hist_pop(int side);
        hist_head[side] = (hist_head[side] + DEPTH - 1) % DEPTH;
        hist_fill[side]--;
        return hist_word[side][hist_head[side]];
    endfunction

    function automatic outcome_t predict_op(logic [1:0] op, logic [63:0] snap);
        outcome_t    r;
        logic [63:0] w;
        w = snap & SNAP_MASK;
        r.cur = w;
        r.st = ST_DONE;
        case (op)
            OP_RECORD:
            begin
                hist_push(UNDO_SIDE, w);
                hist_fill[REDO_SIDE] = 0;
            end
            OP_UNDO:
                if (hist_fill[UNDO_SIDE] == 0)
                    r.st = ST_NO_UNDO;
                else
                begin
                    r.cur = hist_pop(UNDO_SIDE);
                    hist_push(REDO_SIDE, w);
                end
            OP_REDO:
                if (hist_fill[REDO_SIDE] == 0)
                    r.st = ST_NO_REDO;
                else
                begin
                    r.cur = hist_pop(REDO_SIDE);
                    hist_push(UNDO_SIDE, w);
                end
            default: ;
        endcase
        r.undo_lvl = LEVEL_W'(hist_fill[UNDO_SIDE]);
        r.redo_lvl = LEVEL_W'(hist_fill[REDO_SIDE]);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %h got %h", $time, name, exp, act);
            errors++;
        end
    endfunction

    // score result beats, then predict newly accepted beats
    always @(posedge clk)
    begin
        outcome_t  got;
        outcome_t  want;
        outcome_t  calc;
        beat_tag_t tag;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                got.cur = new_current;
                got.st = status;
                got.undo_lvl = undo_level;
                got.redo_lvl = redo_level;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: cur %h status %0d",
                             $time, got.cur, got.st);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("new_current", want.cur, got.cur);
                    check_field("status", 64'(want.st), 64'(got.st));
                    check_field("undo_level", 64'(want.undo_lvl), 64'(got.undo_lvl));
                    check_field("redo_level", 64'(want.redo_lvl), 64'(got.redo_lvl));
                    checked++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                tag = beat_tags.pop_front();
                calc = predict_op(opcode, snapshot);
                op_count[opcode]++;
                if (calc.st != ST_DONE)
                    refusals++;
                pending_results.push_back(tag.typed ? tag.want : calc);
            end
            if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_row(logic [1:0] op, logic [63:0] snap, bit typed,
                                    logic [63:0] cur, logic [1:0] st,
                                    int ul, int rl);
        plan_row_t row;
        row.op = op;
        row.snap = snap;
        row.typed = typed;
        row.want.cur = cur;
        row.want.st = st;
        row.want.undo_lvl = LEVEL_W'(ul);
        row.want.redo_lvl = LEVEL_W'(rl);
        plan.push_back(row);
    endfunction

    task automatic issue(logic [1:0] op, logic [63:0] snap, bit typed, outcome_t want);
        int        gap;
        beat_tag_t tag;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tag.typed = typed;
        tag.want = want;
        beat_tags.push_back(tag);
        start <= 1'b1;
        opcode <= op;
        snapshot <= snap;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // hold off until every expected result has come
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        outcome_t   no_out;
        logic [1:0] op;
        logic [1:0] op_sel;
        bit         mixed;
        bit         first;
        int         issued;
        int         kind;
        int         len;

        no_out = '{default: '0};
        for (int s = 0; s < 2; s++)
        begin
            hist_head[s] = 0;
            hist_fill[s] = 0;
        end
        for (int k = 0; k < 4; k++)
            op_count[k] = 0;

        add_row(OP_UNDO,   64'hA5A5_A5A5_A5A5_A5A5, 1, 64'hA5A5_A5A5_A5A5_A5A5, ST_NO_UNDO, 0, 0);
        add_row(OP_REDO,   64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_NO_REDO, 0, 0);
        add_row(OP_SPARE,  64'h0000_0000_0000_1234, 1, 64'h0000_0000_0000_1234, ST_DONE, 0, 0);
        add_row(OP_RECORD, 64'h0000_0000_0000_0000, 1, 64'h0000_0000_0000_0000, ST_DONE, 1, 0);
        add_row(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_DONE, 2, 0);
        add_row(OP_UNDO,   64'h8000_0000_0000_0001, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_DONE, 1, 1);
        add_row(OP_REDO,   64'h5555_5555_5555_5555, 1, 64'h8000_0000_0000_0001, ST_DONE, 2, 0);
        add_row(OP_UNDO,   64'hAAAA_AAAA_AAAA_AAAA, 1, 64'h5555_5555_5555_5555, ST_DONE, 1, 1);
        add_row(OP_UNDO,   64'h0000_0000_0000_0001, 1, 64'h0000_0000_0000_0000, ST_DONE, 0, 2);
        add_row(OP_UNDO,   64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h7FFF_FFFF_FFFF_FFFF, ST_NO_UNDO, 0, 2);
        add_row(OP_REDO,   64'hFFFF_FFFF_0000_0000, 1, 64'h0000_0000_0000_0001, ST_DONE, 1, 1);
        add_row(OP_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_DONE, 1, 1);
        add_row(OP_RECORD, 64'h0123_4567_89AB_CDEF, 1, 64'h0123_4567_89AB_CDEF, ST_DONE, 2, 0);
        add_row(OP_REDO,   64'h0000_0000_0000_0000, 1, 64'h0000_0000_0000_0000, ST_NO_REDO, 2, 0);
        add_row(OP_UNDO,   64'h3C3C_3C3C_3C3C_3C3C, 0, '0, ST_DONE, 0, 0);
        add_row(OP_UNDO,   64'hC3C3_C3C3_C3C3_C3C3, 0, '0, ST_DONE, 0, 0);
        add_row(OP_UNDO,   64'h0F0F_0F0F_0F0F_0F0F, 0, '0, ST_DONE, 0, 0);
        add_row(OP_REDO,   64'hF0F0_F0F0_F0F0_F0F0, 0, '0, ST_DONE, 0, 0);
        add_row(OP_RECORD, 64'hDEAD_BEEF_0BAD_F00D, 0, '0, ST_DONE, 0, 0);
        add_row(OP_REDO,   64'h1111_2222_3333_4444, 0, '0, ST_DONE, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i].op, plan[i].snap, plan[i].typed, plan[i].want);
        drain();

        issued = 0;
        first = 1'b1;
        while (issued < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            mixed = 1'b0;
            case (kind)
                0, 1, 2:
                begin
                    op_sel = OP_RECORD;
                    len = $urandom_range(1, 80);
                end
                3, 4:
                begin
                    op_sel = OP_UNDO;
                    len = $urandom_range(1, 70);
                end
                5, 6:
                begin
                    op_sel = OP_REDO;
                    len = $urandom_range(1, 70);
                end
                7, 8:
                begin
                    mixed = 1'b1;
                    op_sel = OP_RECORD;
                    len = $urandom_range(1, 20);
                end
                default:
                begin
                    op_sel = OP_SPARE;
                    len = $urandom_range(1, 4);
                end
            endcase
            // overfill the undo history right away
            if (first)
            begin
                mixed = 1'b0;
                op_sel = OP_RECORD;
                len = $urandom_range(DEPTH + 2, DEPTH + 16);
            end
            for (int i = 0; i < len; i++)
            begin
                op = mixed ? 2'($urandom_range(OP_RECORD, OP_REDO)) : op_sel;
                issue(op, rand_word(), 1'b0, no_out);
                if (op != OP_SPARE)
                    issued++;
            end
            first = 1'b0;
            if ($urandom_range(0, 5) == 0)
                drain();
        end

        drain();
        repeat (4) @(posedge clk);

        $display("run covered %0d records, %0d undos, %0d redos, %0d unused opcodes",
                 op_count[OP_RECORD], op_count[OP_UNDO], op_count[OP_REDO],
                 op_count[OP_SPARE]);
        $display("%0d results checked, %0d pushes onto a full history, %0d empty refusals",
                 checked, full_pushes, refusals);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> bounded_undo_redo_history.f
src/burh_pkg.sv
src/burh_cell.sv
src/burh_stack.sv
src/bounded_undo_redo_history.sv
tb/testbench.sv
